>>> hdl/ovn_pkg.sv
// Package for the octave value noise block: sizes, register indexes,
// input kind codes and register reset values. No dependencies.
`default_nettype none
package ovn_pkg;
   localparam int MAX_OCTAVES = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_W      = 16;
   localparam int IDX_W       = MAX_OCTAVES;
   localparam int DEPTH       = 1 << MAX_OCTAVES;
   localparam int NCNT_W      = $clog2(MAX_OCTAVES + 1);
   localparam int OCT_W       = $clog2(MAX_OCTAVES);
   localparam int CNT_W       = 4;
   localparam int MULT_W      = 18;
   localparam int OUT_W       = 32;
   localparam int POS_W       = 32;
   localparam int IN_IDX_W    = 8;
   localparam int IN_VAL_W    = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_MULT  = 2'd1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [CNT_W-1:0]  OCTAVE_COUNT_RESET = 4'd8;
   localparam logic [MULT_W-1:0] OCTAVE_MULT_RESET  = 18'd32768;
endpackage
`default_nettype wire

>>> hdl/octave_value_noise_1d.sv
// Octave value noise, one dimension: sample table, octave sequencer and
// shared multiplier datapath. Depends on ovn_pkg.
//
// Usage: an input beat is taken when start is high and busy is low.
// A load beat (req_kind = 0) writes req_table_value into the sample table
// at req_table_index in that cycle and returns nothing; busy stays low.
// A query beat (req_kind = 1) uses the fraction of req_position. Each
// octave steps through address, interpolation, rounding, term and weight
// states on one shared 33x19 multiplier (segment interpolation, term
// weighting, weight update) and a two-port table read; a query runs 2 to
// 8 octaves. busy is high until the result; the next beat is taken in the
// cycle the result appears. The result is on rsp_noise_value for one cycle
// with rsp_valid high; the receiver cannot stall it.
// Registers are written through csr_we/csr_index/csr_wdata while idle:
// index 0 octave count, index 1 octave multiplier; other indexes ignored.
// Reset (synchronous) restores the register defaults and returns to idle;
// the sample table is not cleared and must be loaded before queries.
`default_nettype none
module octave_value_noise_1d (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_kind,
   input  wire logic [ovn_pkg::IN_IDX_W-1:0]        req_table_index,
   input  wire logic [ovn_pkg::IN_VAL_W-1:0]        req_table_value,
   input  wire logic signed [ovn_pkg::POS_W-1:0]    req_position,
   output logic                                     rsp_valid,
   output logic [ovn_pkg::OUT_W-1:0]                rsp_noise_value,
   input  wire logic                                csr_we,
   input  wire logic [ovn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ovn_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   localparam int SB       = ovn_pkg::SAMPLE_BITS;
   localparam int MUL_A_W  = 33;
   localparam int MUL_B_W  = ovn_pkg::MULT_W + 1;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int RND_W    = PROD_W - 1;
   localparam int RH_W     = RND_W - 16;
   localparam int ACC_W    = SB + 18;
   localparam int INTERP_W = 17;

   typedef enum logic [2:0] {
      S_IDLE, S_ADDR, S_INTERP, S_ROUND, S_TERM, S_WEIGHT
   } state_type;

   state_type state_ff;
   logic [ovn_pkg::CNT_W-1:0]   octave_count_ff;
   logic [ovn_pkg::MULT_W-1:0]  octave_mult_ff;
   logic                        rsp_valid_ff;
   logic [ovn_pkg::OUT_W-1:0]   rsp_noise_value_ff;
   logic [ovn_pkg::OCT_W-1:0]   oct_ff;
   logic [ovn_pkg::NCNT_W-1:0]  n_ff;

   logic [SB-1:0]               mem [ovn_pkg::DEPTH];
   logic [SB-1:0]               p0_ff, p1_ff;
   logic [ovn_pkg::FRAC_W-1:0]  frac_ff;
   logic [31:0]                 weight_ff;
   logic [31:0]                 sum_ff;
   logic [INTERP_W-1:0]         interp_ff;
   logic signed [PROD_W-1:0]    prod_ff;

   logic                        accept;
   logic [ovn_pkg::CNT_W-1:0]   cnt_clamp;
   logic [ovn_pkg::NCNT_W-1:0]  shift_amt;
   logic [ovn_pkg::FRAC_W-1:0]  frac_shift;
   logic [ovn_pkg::IDX_W:0]     step;
   logic [ovn_pkg::IDX_W:0]     low_bits;
   logic [ovn_pkg::IDX_W:0]     idx_mask;
   logic [ovn_pkg::IDX_W:0]     i1_sum;
   logic [ovn_pkg::IDX_W-1:0]   i0, i1;
   logic [ovn_pkg::FRAC_W-1:0]  seg_t;
   logic signed [SB:0]          diff;
   logic signed [MUL_A_W-1:0]   a_op;
   logic signed [MUL_B_W-1:0]   b_op;
   logic signed [PROD_W-1:0]    prod_in;
   logic [ACC_W-1:0]            acc;
   logic [RND_W-1:0]            rnd;
   logic [RH_W-1:0]             rnd_hi;
   logic [RH_W:0]               sum_wide;
   logic [31:0]                 sum_sat;
   logic [31:0]                 weight_sat;
   logic                        last;

   assign busy            = (state_ff != S_IDLE);
   assign accept          = start && !busy;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;

   always_comb begin
      if (octave_count_ff < ovn_pkg::CNT_W'(2)) begin
         cnt_clamp = ovn_pkg::CNT_W'(2);
      end else if (octave_count_ff > ovn_pkg::CNT_W'(ovn_pkg::MAX_OCTAVES)) begin
         cnt_clamp = ovn_pkg::CNT_W'(ovn_pkg::MAX_OCTAVES);
      end else begin
         cnt_clamp = octave_count_ff;
      end
   end

   // segment end addresses for the current octave
   assign shift_amt  = n_ff - ovn_pkg::NCNT_W'(oct_ff);
   assign frac_shift = frac_ff >> (5'(ovn_pkg::FRAC_W) - 5'(n_ff));
   assign step       = (ovn_pkg::IDX_W+1)'(1) << shift_amt;
   assign low_bits   = step - (ovn_pkg::IDX_W+1)'(1);
   assign idx_mask   = ((ovn_pkg::IDX_W+1)'(1) << n_ff) - (ovn_pkg::IDX_W+1)'(1);
   assign i0         = frac_shift[ovn_pkg::IDX_W-1:0] & ~low_bits[ovn_pkg::IDX_W-1:0];
   assign i1_sum     = {1'b0, i0} + step;
   assign i1         = i1_sum[ovn_pkg::IDX_W-1:0] & idx_mask[ovn_pkg::IDX_W-1:0];

   assign seg_t = frac_ff << oct_ff;
   assign diff  = $signed({1'b0, p1_ff}) - $signed({1'b0, p0_ff});
   assign last  = (ovn_pkg::NCNT_W'(oct_ff) + ovn_pkg::NCNT_W'(1)) == n_ff;

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         S_INTERP: begin
            a_op = MUL_A_W'(diff);
            b_op = $signed(MUL_B_W'(seg_t));
         end
         S_TERM: begin
            a_op = $signed(MUL_A_W'(weight_ff));
            b_op = $signed(MUL_B_W'(interp_ff));
         end
         S_WEIGHT: begin
            a_op = $signed(MUL_A_W'(weight_ff));
            b_op = $signed(MUL_B_W'(octave_mult_ff));
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
   end

   assign prod_in = a_op * b_op;

   assign acc = {2'b00, p0_ff, 16'h0000} + prod_ff[ACC_W-1:0]
                + (ACC_W'(1) << (SB - 1));

   assign rnd      = prod_ff[RND_W-1:0] + RND_W'(32'h8000);
   assign rnd_hi   = rnd[RND_W-1:16];
   assign sum_wide = (RH_W+1)'(sum_ff) + (RH_W+1)'(rnd_hi);
   assign sum_sat  = (sum_wide[RH_W:32] != '0) ? 32'hFFFF_FFFF : sum_wide[31:0];
   assign weight_sat = (rnd_hi[RH_W-1:32] != '0) ? 32'hFFFF_FFFF : rnd_hi[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         octave_count_ff <= ovn_pkg::OCTAVE_COUNT_RESET;
         octave_mult_ff  <= ovn_pkg::OCTAVE_MULT_RESET;
         oct_ff          <= '0;
         n_ff            <= ovn_pkg::NCNT_W'(ovn_pkg::MAX_OCTAVES);
      end else begin
         rsp_valid_ff <= (state_ff == S_WEIGHT) && last;
         if (csr_we) begin
            if (csr_index == ovn_pkg::CSR_OCTAVE_COUNT) begin
               octave_count_ff <= csr_wdata[ovn_pkg::CNT_W-1:0];
            end else if (csr_index == ovn_pkg::CSR_OCTAVE_MULT) begin
               octave_mult_ff <= csr_wdata[ovn_pkg::MULT_W-1:0];
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_kind == ovn_pkg::KIND_QUERY) begin
                  oct_ff   <= '0;
                  n_ff     <= cnt_clamp[ovn_pkg::NCNT_W-1:0];
                  state_ff <= S_ADDR;
               end
            end
            S_ADDR:   state_ff <= S_INTERP;
            S_INTERP: state_ff <= S_ROUND;
            S_ROUND:  state_ff <= S_TERM;
            S_TERM:   state_ff <= S_WEIGHT;
            S_WEIGHT: begin
               if (last) begin
                  rsp_noise_value_ff <= sum_sat;
                  state_ff           <= S_IDLE;
               end else begin
                  oct_ff   <= oct_ff + ovn_pkg::OCT_W'(1);
                  state_ff <= S_ADDR;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (accept) begin
         frac_ff   <= req_position[ovn_pkg::FRAC_W-1:0];
         weight_ff <= 32'(octave_mult_ff);
         sum_ff    <= '0;
      end
      if (state_ff == S_ADDR && oct_ff != '0) begin
         weight_ff <= weight_sat;
      end
      if (state_ff == S_ROUND) begin
         interp_ff <= acc[SB+INTERP_W-1:SB];
      end
      if (state_ff == S_WEIGHT) begin
         sum_ff <= sum_sat;
      end
   end

   // sample table, two registered read ports
   always_ff @(posedge clock) begin
      if (accept && req_kind == ovn_pkg::KIND_LOAD) begin
         mem[ovn_pkg::IDX_W'(req_table_index)] <= SB'(req_table_value);
      end
      if (state_ff == S_ADDR) begin
         p0_ff <= mem[i0];
         p1_ff <= mem[i1];
      end
   end
endmodule
`default_nettype wire

>>> verif/octave_value_noise_1d_tb.sv
// Self-checking testbench for octave_value_noise_1d: fills the sample table,
// runs directed and random load/query beats under several register settings.
// Depends on ovn_pkg and the octave_value_noise_1d RTL.
module octave_value_noise_1d_tb;
   import ovn_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int PHASES     = 9;
   localparam int PHASE_BEATS = 110;
   localparam int SETTLE_CYCLES = 48;

   class noise_tracker;
      logic [SAMPLE_BITS-1:0] samples [DEPTH];
      logic [CNT_W-1:0]       oct_cnt;
      logic [MULT_W-1:0]      oct_mult;
      logic [OUT_W-1:0]       expected_noise [$];
      int                     errors;

      function new();
         oct_cnt  = OCTAVE_COUNT_RESET;
         oct_mult = OCTAVE_MULT_RESET;
         errors   = 0;
         foreach (samples[i]) samples[i] = '0;
      endfunction

      task report(string msg);
         $display("ERROR %0t: %s", $time, msg);
         errors++;
      endtask

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_OCTAVE_COUNT)
            oct_cnt = data[CNT_W-1:0];
         else if (idx == CSR_OCTAVE_MULT)
            oct_mult = data[MULT_W-1:0];
      endfunction

      function logic [OUT_W-1:0] noise_at(logic [FRAC_W-1:0] frac);
         int unsigned n, stp, seg, t, i0, i1, mask;
         logic [63:0] weight, sum, acc, interp, term, p0, p1;
         n = (oct_cnt < 2) ? 2 : (oct_cnt > MAX_OCTAVES) ? MAX_OCTAVES : oct_cnt;
         mask = (1 << n) - 1;
         weight = 64'(oct_mult);
         sum = '0;
         for (int i = 0; i < n; i++) begin
            stp = 1 << (n - i);
            seg = 32'(frac) >> (16 - i);
            t   = (32'(frac) << i) & 32'hFFFF;
            i0  = (seg * stp) & mask;
            i1  = ((seg + 1) * stp) & mask;
            p0  = 64'(samples[IDX_W'(i0)]);
            p1  = 64'(samples[IDX_W'(i1)]);
            acc = p0 * (64'd65536 - 64'(t)) + p1 * 64'(t);
            interp = (acc + (64'd1 << (SAMPLE_BITS - 1))) >> SAMPLE_BITS;
            term = (interp * weight + 64'h8000) >> 16;
            sum += term;
            if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
            weight = (weight * 64'(oct_mult) + 64'h8000) >> 16;
            if (weight > 64'hFFFF_FFFF) weight = 64'hFFFF_FFFF;
         end
         return sum[OUT_W-1:0];
      endfunction

      function void note_beat(logic kind, logic [IN_IDX_W-1:0] idx,
                              logic [IN_VAL_W-1:0] val, logic [POS_W-1:0] pos);
         if (kind == KIND_LOAD)
            samples[idx[IDX_W-1:0]] = val[SAMPLE_BITS-1:0];
         else
            expected_noise.push_back(noise_at(pos[FRAC_W-1:0]));
      endfunction

      task check_noise(logic [OUT_W-1:0] got);
         logic [OUT_W-1:0] want;
         if (expected_noise.size() == 0) begin
            report($sformatf("unexpected result noise_value=%h", got));
         end else begin
            want = expected_noise.pop_front();
            if (got !== want)
               report($sformatf("noise_value got %h want %h", got, want));
         end
      endtask

      function int pending();
         return expected_noise.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_kind = KIND_LOAD;
   logic [IN_IDX_W-1:0]       req_table_index = '0;
   logic [IN_VAL_W-1:0]       req_table_value = '0;
   logic signed [POS_W-1:0]   req_position = '0;
   logic                      rsp_valid;
   logic [OUT_W-1:0]          rsp_noise_value;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   noise_tracker tracker;
   bit           no_gaps = 1'b0;

   octave_value_noise_1d DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) tracker.write_reg(csr_index, csr_wdata);
         if (rsp_valid) tracker.check_noise(rsp_noise_value);
         if (start && !busy)
            tracker.note_beat(req_kind, req_table_index, req_table_value, req_position);
      end
   end

   task send_beat(input logic kind, input logic [IN_IDX_W-1:0] idx,
                  input logic [IN_VAL_W-1:0] val, input logic [POS_W-1:0] pos);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_kind        <= kind;
      req_table_index <= idx;
      req_table_value <= val;
      req_position    <= pos;
      do @(posedge clock); while (busy);
   endtask

   task load_beat(input logic [IN_IDX_W-1:0] idx, input logic [IN_VAL_W-1:0] val);
      send_beat(KIND_LOAD, idx, val, $urandom());
   endtask

   task query_beat(input logic [POS_W-1:0] pos);
      send_beat(KIND_QUERY, IN_IDX_W'($urandom()), IN_VAL_W'($urandom()), pos);
   endtask

   task drain_results();
      start <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // upper data bits of the count write are junk; spare index must be ignored
   task configure(input logic [CNT_W-1:0] cnt, input logic [MULT_W-1:0] mult);
      settle();
      set_reg(CSR_OCTAVE_COUNT, {14'($urandom()), cnt});
      set_reg(CSR_OCTAVE_MULT, mult);
      set_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, 18'($urandom()));
   endtask

   function logic [POS_W-1:0] pick_position();
      logic [POS_W-1:0] pos;
      pos = $urandom();
      case ($urandom_range(0, 9))
         0, 1: pos[FRAC_W-1:0] = pos[FRAC_W-1:0] & ~16'((1 << $urandom_range(8, 16)) - 1);
         2: pos[FRAC_W-1:0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         3: pos[FRAC_W-1:0] = 16'(1 << $urandom_range(0, 15));
         default: ;
      endcase
      return pos;
   endfunction

   initial begin
      int cnt;
      logic [MULT_W-1:0] mult;
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DEPTH; i++) load_beat(IN_IDX_W'(i), IN_VAL_W'($urandom()));

      // reset defaults: 8 octaves, factor 0.5
      load_beat(8'd0, 16'hFFFF);
      load_beat(8'd128, 16'h0000);
      query_beat(32'h0000_0000);
      query_beat(32'h0000_FFFF);
      query_beat(32'h0000_8000);
      query_beat(32'hFFFF_C000);
      query_beat(32'h7FFF_FFFF);
      query_beat(32'h8000_0000);
      query_beat(32'h0001_4000);

      configure(4'd2, 18'h3FFFF);
      query_beat(32'h0000_0000);
      query_beat(32'h0000_FFFF);
      query_beat(32'hFFFF_4000);
      load_beat(8'd200, 16'h1234);   // outside the table in use
      query_beat(32'h0000_C000);

      configure(4'd0, 18'h10000);    // count below range
      query_beat(32'h1234_6000);
      configure(4'd15, 18'h3FFFF);   // count above range, heavy weights
      for (int i = 0; i < DEPTH; i += 32) load_beat(IN_IDX_W'(i), 16'hFFFF);
      query_beat(32'h0000_0000);
      query_beat(32'h0000_A5A5);
      configure(4'd8, 18'h00000);
      query_beat(32'h0000_7777);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin cnt = 8;  mult = 18'd32768;  end
            1: begin cnt = 2;  mult = 18'h3FFFF;  end
            2: begin cnt = 5;  mult = 18'd0;      end
            3: begin cnt = 15; mult = 18'd65536;  end
            4: begin cnt = 3;  mult = MULT_W'($urandom_range(0, 262143)); end
            5: begin cnt = 0;  mult = 18'd1;      end
            6: begin cnt = 7;  mult = 18'h3FFFF;  end
            7: begin cnt = 4;  mult = 18'd98304;  end
            default: begin cnt = 6; mult = MULT_W'($urandom_range(0, 262143)); end
         endcase
         configure(CNT_W'(cnt), mult);
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PHASE_BEATS; k++) begin
            if ($urandom_range(0, 3) == 0)
               load_beat(IN_IDX_W'($urandom()), IN_VAL_W'($urandom()));
            else
               query_beat(pick_position());
            if ($urandom_range(0, 49) == 0) drain_results();
         end
      end

      settle();
      if (tracker.pending() != 0)
         tracker.report($sformatf("%0d results never arrived", tracker.pending()));
      if (tracker.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
